// ===== rtl/core/ssbd_pkg.sv =====
package ssbd_pkg;

  // Default sizing of the block.
  localparam int unsigned DEF_MAX_OUT_WIDTH = 1024;
  localparam int unsigned DEF_MAX_FACTOR    = 8;

  // Fixed limits and field widths.
  localparam int unsigned MAX_OUT_HEIGHT = 1024;
  localparam int unsigned FULL_SCALE     = 255;
  localparam int unsigned PIX_W          = 16;
  localparam int unsigned OUT_W          = 8;
  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned S_DATA_W       = NUM_CH * PIX_W;
  localparam int unsigned M_DATA_W       = NUM_CH * OUT_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned FACTOR_CFG_W = 4;
  localparam int unsigned HEIGHT_W     = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR     = 2'd0,
    CFG_OUT_WIDTH  = 2'd1,
    CFG_OUT_HEIGHT = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/core/ssbd_ram.sv =====
module ssbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; the read data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/supersample_box_downscale_core.sv =====
// Channel   Direction  Handshake                Contents
// s_*       in         s_tvalid_i / s_tready_o  one sub-pixel word, red, green, blue
// m_*       out        m_tvalid_o / m_tready_i  one output pixel word, tlast on frame end
// cfg_*     in         cfg_we_i                 factor, output width, output height
//
// One sub-pixel word is taken per clock while the output register is free or being
// drained. The edge that takes the last sub-pixel of a block also registers the
// accumulator memory read; the add and write back follow, with the last written sum
// forwarded to the next word, then the divide stage is loaded, and the output
// register behind it raises m_tvalid_o.
// A stalled output register holds the whole pipeline and input ready drops.
// Reset clears the position counters and pipeline valids; the accumulators are not
// cleared, since the first sub-pixel of every block row loads its column entry.
module supersample_box_downscale_core
  import ssbd_pkg::*;
#(
  parameter int unsigned MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int unsigned MAX_FACTOR    = DEF_MAX_FACTOR
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Fields from bit 0 up: red_in[15:0], green_in[31:16], blue_in[47:32].
  input  logic [S_DATA_W-1:0]   s_tdata_i,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // Fields from bit 0 up: red_out[7:0], green_out[15:8], blue_out[23:16].
  output logic [M_DATA_W-1:0]   m_tdata_o,
  // frame_end.
  output logic                  m_tlast_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW     = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int unsigned WW     = $clog2(MAX_OUT_WIDTH + 1);
  localparam int unsigned FW     = $clog2(MAX_FACTOR + 1);
  localparam int unsigned SW     = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int unsigned BRW    = $clog2(MAX_OUT_HEIGHT);
  localparam int unsigned SQ_W   = $clog2(MAX_FACTOR * MAX_FACTOR);
  localparam int unsigned SUM_W  = PIX_W + SQ_W;
  localparam int unsigned TW     = OUT_W + SQ_W;
  localparam int unsigned K      = OUT_W + 4 * $clog2(MAX_FACTOR);
  localparam int unsigned RW     = K + 1;
  localparam int unsigned PW     = TW + RW;
  localparam int unsigned MEM_W  = NUM_CH * SUM_W;

  // Configuration registers.
  logic [FACTOR_CFG_W-1:0] cfg_factor_q;
  logic [CFG_DATA_W-1:0]   cfg_width_q;
  logic [HEIGHT_W-1:0]     cfg_height_q;
  logic                    cfg_hit;

  // Raster position.
  logic [SW-1:0]  sub_col_q, sub_col_d;
  logic [SW-1:0]  sub_row_q, sub_row_d;
  logic [AW-1:0]  blk_col_q, blk_col_d;
  logic [BRW-1:0] blk_row_q, blk_row_d;

  // Effective configuration after clamping.
  logic [FW-1:0]       f_eff;
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic adv;
  logic accept;
  logic sc_end, bc_end, sr_end, br_end;

  // Accumulate stage.
  logic                    s1_v_q;
  logic                    s1_load_q;
  logic                    s1_emit_q;
  logic                    s1_last_q;
  logic [AW-1:0]           s1_col_q;
  logic [S_DATA_W-1:0]     s1_pix_q;
  logic [MEM_W-1:0]        rd_data;
  logic [MEM_W-1:0]        base_sums;
  logic [MEM_W-1:0]        new_sums;
  logic [NUM_CH*TW-1:0]    scaled;

  // Forwarding of the most recent write.
  logic                    fwd_v_q;
  logic [AW-1:0]           fwd_col_q;
  logic [MEM_W-1:0]        fwd_sums_q;

  // Divide stage.
  logic                    s2_v_q;
  logic                    s2_last_q;
  logic [NUM_CH*TW-1:0]    s2_t_q;
  logic [RW-1:0]           rcp_tab [MAX_FACTOR+1];
  logic [RW-1:0]           rcp;
  logic [M_DATA_W-1:0]     quot;

  // Output register.
  logic                    out_v_q;
  logic                    out_last_q;
  logic [M_DATA_W-1:0]     out_data_q;

  // Clamp the registers to their working ranges.
  always_comb begin
    if (cfg_factor_q == '0) begin
      f_eff = FW'(1);
    end else if (32'(cfg_factor_q) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(cfg_factor_q);
    end
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_q) > MAX_OUT_WIDTH) begin
      w_eff = WW'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (32'(cfg_height_q) > MAX_OUT_HEIGHT) begin
      h_eff = HEIGHT_W'(MAX_OUT_HEIGHT);
    end else begin
      h_eff = cfg_height_q;
    end
  end

  // Configuration writes; any valid index restarts the frame position.
  always_comb begin
    case (cfg_idx_i)
      CFG_FACTOR, CFG_OUT_WIDTH, CFG_OUT_HEIGHT: cfg_hit = cfg_we_i;
      default:                                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_factor_q <= FACTOR_CFG_W'(1);
      cfg_width_q  <= CFG_DATA_W'(1024);
      cfg_height_q <= HEIGHT_W'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FACTOR:     cfg_factor_q <= cfg_data_i[FACTOR_CFG_W-1:0];
        CFG_OUT_WIDTH:  cfg_width_q  <= cfg_data_i;
        CFG_OUT_HEIGHT: cfg_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default:        ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is empty or drained.
  assign adv        = !out_v_q || m_tready_i;
  assign accept     = s_tvalid_i && adv;
  assign s_tready_o = adv;

  // Raster position advance.
  assign sc_end = (32'(sub_col_q) + 1) >= 32'(f_eff);
  assign sr_end = (32'(sub_row_q) + 1) >= 32'(f_eff);
  assign bc_end = (32'(blk_col_q) + 1) >= 32'(w_eff);
  assign br_end = (32'(blk_row_q) + 1) >= 32'(h_eff);

  always_comb begin
    sub_col_d = sub_col_q;
    sub_row_d = sub_row_q;
    blk_col_d = blk_col_q;
    blk_row_d = blk_row_q;
    if (!sc_end) begin
      sub_col_d = sub_col_q + SW'(1);
    end else begin
      sub_col_d = '0;
      if (!bc_end) begin
        blk_col_d = blk_col_q + AW'(1);
      end else begin
        blk_col_d = '0;
        if (!sr_end) begin
          sub_row_d = sub_row_q + SW'(1);
        end else begin
          sub_row_d = '0;
          blk_row_d = br_end ? '0 : blk_row_q + BRW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_col_q <= '0;
      sub_row_q <= '0;
      blk_col_q <= '0;
      blk_row_q <= '0;
    end else if (cfg_hit) begin
      sub_col_q <= '0;
      sub_row_q <= '0;
      blk_col_q <= '0;
      blk_row_q <= '0;
    end else if (accept) begin
      sub_col_q <= sub_col_d;
      sub_row_q <= sub_row_d;
      blk_col_q <= blk_col_d;
      blk_row_q <= blk_row_d;
    end
  end

  // Line accumulators for all three channels in one memory.
  ssbd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (adv && s1_v_q),
    .waddr_i (s1_col_q),
    .wdata_i (new_sums),
    .re_i    (accept),
    .raddr_i (blk_col_q),
    .rdata_o (rd_data)
  );

  // Accept stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_load_q <= (sub_row_q == '0) && (sub_col_q == '0);
      s1_emit_q <= sr_end && sc_end;
      s1_last_q <= bc_end && br_end;
      s1_col_q  <= blk_col_q;
      s1_pix_q  <= s_tdata_i;
    end
  end

  // The word read in the cycle of a write to the same column takes the forwarded sums.
  assign base_sums = (fwd_v_q && (fwd_col_q == s1_col_q)) ? fwd_sums_q : rd_data;

  // Add or load each channel, then scale by 255 and drop the 16 fraction bits.
  always_comb begin
    logic [SUM_W-1:0]   sum;
    logic [SUM_W+7:0]   sum255;
    for (int c = 0; c < NUM_CH; c++) begin
      if (s1_load_q) begin
        sum = SUM_W'(s1_pix_q[c*PIX_W +: PIX_W]);
      end else begin
        sum = base_sums[c*SUM_W +: SUM_W] + SUM_W'(s1_pix_q[c*PIX_W +: PIX_W]);
      end
      new_sums[c*SUM_W +: SUM_W] = sum;
      sum255 = {sum, 8'b0} - (SUM_W+8)'(sum);
      scaled[c*TW +: TW] = sum255[SUM_W+7:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (adv && s1_v_q) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      fwd_col_q  <= s1_col_q;
      fwd_sums_q <= new_sums;
    end
  end

  // Divide stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q && s1_emit_q) begin
      s2_t_q    <= scaled;
      s2_last_q <= s1_last_q;
    end
  end

  // Reciprocals of factor squared, exact for every quotient below 256.
  for (genvar gi = 0; gi <= MAX_FACTOR; gi++) begin : g_rcp
    localparam longint unsigned Div = (gi == 0) ? 1 : gi * gi;
    localparam logic [RW-1:0] Rcp = RW'(((64'd1 << K) + Div - 1) / Div);
    assign rcp_tab[gi] = Rcp;
  end

  assign rcp = rcp_tab[f_eff];

  // Divide by factor squared through the reciprocal, saturating at full scale.
  always_comb begin
    logic [PW-1:0] prod;
    logic [TW:0]   q;
    for (int c = 0; c < NUM_CH; c++) begin
      prod = PW'(s2_t_q[c*TW +: TW]) * PW'(rcp);
      q    = prod[PW-1:K];
      if (32'(q) > FULL_SCALE) begin
        quot[c*OUT_W +: OUT_W] = OUT_W'(FULL_SCALE);
      end else begin
        quot[c*OUT_W +: OUT_W] = q[OUT_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      out_data_q <= quot;
      out_last_q <= s2_last_q;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ===== rtl/core/ssbd_chk.sv =====
module ssbd_chk
  import ssbd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tready_o,
  input logic [M_DATA_W-1:0]   m_tdata_o,
  input logic                  m_tlast_o,
  input logic                  m_tvalid_o,
  input logic                  m_tready_i
);

  // A result word that is not taken stays offered.
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> m_tvalid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its data and frame flag.
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> ($stable(m_tdata_o) && $stable(m_tlast_o)))
    else $error("result word changed while stalled");

  // Input is held off exactly while a result word waits.
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (!m_tvalid_o || m_tready_i))
    else $error("input ready does not follow the output register");

  // A cycle under reset leaves the output register empty.
  a_reset_empties: assert property (@(posedge clk_i)
    !rst_ni |=> !m_tvalid_o)
    else $error("result offered after reset");

endmodule

bind supersample_box_downscale_core ssbd_chk u_ssbd_chk (.*);
